/* design/occupancy_grid_distance_field_macros.svh */
// assertion macros for the occupancy grid distance field
// expects clk and arst_n in the scope where a macro is used
`ifndef OCCUPANCY_GRID_DISTANCE_FIELD_MACROS_SVH
`define OCCUPANCY_GRID_DISTANCE_FIELD_MACROS_SVH

// condition implies consequence in the same cycle
`define OGDF_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define OGDF_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* design/ogdf_pkg.sv */
// shared types and constants of the occupancy grid distance field
// no dependencies
package ogdf_pkg;

	localparam int DIST_BITS = 20;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
	localparam logic [8:0] STEP_ORTHO = 9'd256;
	localparam logic [8:0] STEP_DIAG = 9'd362;

	localparam int DIM_BITS = 9;
	localparam int THR_BITS = 7;
	localparam logic [DIM_BITS-1:0] WIDTH_RESET = 9'd256;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 9'd256;
	localparam logic [THR_BITS-1:0] THR_RESET = 7'd65;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	// command opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_MAP = 3'd1,
		ST_RANGE = 3'd2,
		ST_SIZE = 3'd3,
		ST_NO_OBST = 3'd4
	} status_t;

	typedef struct packed {
		logic op;
		logic signed [7:0] occupancy;
		logic last_cell;
		logic [15:0] cell_index;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic map_valid;
		logic [DIST_BITS-1:0] distance;
	} rsp_t;

endpackage

/* design/occupancy_grid_distance_field.sv */
// top level of the occupancy grid distance field: cell store, loader and sweep sequencer
// depends on ogdf_pkg and occupancy_grid_distance_field_macros.svh
//
// usage
// - cmd channel (cmd_valid / cmd_stall / cmd) carries one word per command: a load word
//   writes the next grid cell in raster order, a read word asks for the distance of
//   one cell by raster index
// - rsp channel (rsp_valid / rsp_stall / rsp) returns one word per read and one word
//   for the load that has last_cell set; plain loads return nothing
// - cfg port (cfg_write / cfg_index / cfg_data) sets width, height and threshold;
//   write it only while the block is idle
// - a plain load writes its cell as it is accepted; a read goes through S_RDOUT, where
//   the read data is registered into its response word
// - the final load goes through S_CHECK, then iterations of a forward and a backward sweep
//   over all cells; iterations repeat until a full iteration changes nothing, then S_FIN
// - the per-cell cost is set by the single memory read port: center and four
//   neighbors are read one after the other through one adder and one compare
// - cmd_stall is high while the block is not idle (read, check, sweep or finish), and
//   while a finished response word is held and rsp_stall is high
// - reset clears the map, the load count and the held field; the cell memory is not
//   cleared, a map load writes every cell it covers
module occupancy_grid_distance_field #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [1:0] cfg_index,
	input logic [ogdf_pkg::DIM_BITS-1:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_stall,
	input ogdf_pkg::cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_stall,
	output ogdf_pkg::rsp_t rsp
);

`include "occupancy_grid_distance_field_macros.svh"

	localparam int DB = ogdf_pkg::DIST_BITS;
	localparam int CELL_CAP = MAX_WIDTH * MAX_HEIGHT;
	// memory address bits
	localparam int AB = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
	// count bits: holds the saturated load count and the width times height product
	localparam int CNT_RAW = $clog2(CELL_CAP + 2);
	localparam int CW = (CNT_RAW > 18) ? CNT_RAW : 18;
	// coordinate bits
	localparam int XB = $clog2(MAX_WIDTH + 1);
	localparam int YB = $clog2(MAX_HEIGHT + 1);

	// phases of one cell: center read, four neighbor reads, final compare and write
	localparam logic [2:0] PH_CTR = 3'd0;
	localparam logic [2:0] PH_N1 = 3'd1;
	localparam logic [2:0] PH_N2 = 3'd2;
	localparam logic [2:0] PH_N3 = 3'd3;
	localparam logic [2:0] PH_N4 = 3'd4;
	localparam logic [2:0] PH_WR = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDOUT = 5'b00010,
		S_CHECK = 5'b00100,
		S_SWEEP = 5'b01000,
		S_FIN = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ogdf_pkg::DIM_BITS-1:0] width_q, height_q;
	logic [ogdf_pkg::THR_BITS-1:0] thr_q;

	// map bookkeeping
	logic [CW-1:0] load_count_q;
	logic obstacle_q;
	logic field_valid_q;
	logic [ogdf_pkg::DIM_BITS-1:0] held_w_q, held_h_q;
	logic [CW-1:0] held_cells_q;

	// read path
	ogdf_pkg::status_t rd_status_q;

	// response register
	logic rsp_valid_q;
	ogdf_pkg::rsp_t rsp_q;

	// sweep sequencer
	logic bwd_q;
	logic [XB-1:0] x_q;
	logic [YB-1:0] y_q;
	logic [AB-1:0] i_q;
	logic [2:0] ph_q;
	logic [DB-1:0] cur_q;
	logic dirty_q;
	logic changed_q;
	logic slot_ok_s1;

	// cell memory
	logic [DB-1:0] dist_mem [CELL_CAP];
	logic [DB-1:0] mem_rdata_q;
	logic mem_we;
	logic [AB-1:0] mem_waddr, mem_raddr;
	logic [DB-1:0] mem_wdata;

	logic cmd_accept, rsp_accept;
	logic occupied;
	logic [CW-1:0] idx_ext;
	logic [17:0] dims_prod;
	logic dims_ok;

	logic x_lo, x_hi, y_lo, y_hi;
	logic [AB-1:0] w_a;
	logic [AB-1:0] nb_addr;
	logic nb_ok;
	logic [AB-1:0] sweep_addr;
	logic [DB:0] cand_sum;
	logic [DB-1:0] cand;
	logic better;
	logic [DB-1:0] cur_d;
	logic dirty_d;

	assign rsp_accept = rsp_valid_q && !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// obstacle test, negative occupancy never reaches a non-negative threshold
	assign occupied = $signed(cmd.occupancy) >= $signed({1'b0, thr_q});
	assign idx_ext = CW'(cmd.cell_index);

	assign dims_prod = 18'(width_q) * 18'(height_q);
	assign dims_ok = (width_q != '0) && (height_q != '0)
		&& (32'(width_q) <= 32'(MAX_WIDTH)) && (32'(height_q) <= 32'(MAX_HEIGHT));

	// neighbor bounds of the current cell
	assign x_lo = x_q != '0;
	assign y_lo = y_q != '0;
	assign x_hi = (32'(x_q) + 32'd1) < 32'(held_w_q);
	assign y_hi = (32'(y_q) + 32'd1) < 32'(held_h_q);
	assign w_a = AB'(held_w_q);

	// neighbor address for the slot read in this phase
	always_comb begin
		nb_addr = i_q;
		nb_ok = 1'b0;
		case (ph_q)
			PH_N1: begin
				nb_addr = bwd_q ? i_q + AB'(1) : i_q - AB'(1);
				nb_ok = bwd_q ? x_hi : x_lo;
			end
			PH_N2: begin
				nb_addr = bwd_q ? i_q + w_a : i_q - w_a;
				nb_ok = bwd_q ? y_hi : y_lo;
			end
			PH_N3: begin
				nb_addr = bwd_q ? i_q + w_a + AB'(1) : i_q - w_a - AB'(1);
				nb_ok = bwd_q ? (x_hi && y_hi) : (x_lo && y_lo);
			end
			PH_N4: begin
				nb_addr = bwd_q ? i_q + w_a - AB'(1) : i_q - w_a + AB'(1);
				nb_ok = bwd_q ? (y_hi && x_lo) : (y_lo && x_hi);
			end
			default: begin
				nb_addr = i_q;
				nb_ok = 1'b0;
			end
		endcase
		sweep_addr = nb_ok ? nb_addr : i_q;
	end

	// shared relax unit: saturating add of the step cost, compare against the center
	always_comb begin
		cand_sum = {1'b0, mem_rdata_q}
			+ ((ph_q == PH_N4 || ph_q == PH_WR) ? (DB+1)'(ogdf_pkg::STEP_DIAG)
				: (DB+1)'(ogdf_pkg::STEP_ORTHO));
		cand = cand_sum[DB] ? ogdf_pkg::DIST_MAX : cand_sum[DB-1:0];
		better = (ph_q != PH_CTR) && (ph_q != PH_N1) && slot_ok_s1 && (cand < cur_q);
		cur_d = better ? cand : cur_q;
		dirty_d = dirty_q || better;
	end

	// memory port selection: loads write in idle, the sweep writes back improved cells
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = i_q;
		mem_wdata = cur_d;
		mem_raddr = sweep_addr;
		if (state_q == S_IDLE) begin
			mem_raddr = AB'(idx_ext);
			mem_waddr = AB'(load_count_q);
			mem_wdata = occupied ? '0 : ogdf_pkg::DIST_MAX;
			mem_we = cmd_accept && (cmd.op == ogdf_pkg::OP_LOAD)
				&& (load_count_q < CW'(CELL_CAP));
		end else if (state_q == S_SWEEP) begin
			mem_we = (ph_q == PH_WR) && dirty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dist_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= dist_mem[mem_raddr];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ogdf_pkg::WIDTH_RESET;
			height_q <= ogdf_pkg::HEIGHT_RESET;
			thr_q <= ogdf_pkg::THR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ogdf_pkg::REG_WIDTH: width_q <= cfg_data;
				ogdf_pkg::REG_HEIGHT: height_q <= cfg_data;
				ogdf_pkg::REG_THRESHOLD: thr_q <= cfg_data[ogdf_pkg::THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			load_count_q <= '0;
			obstacle_q <= 1'b0;
			field_valid_q <= 1'b0;
			held_w_q <= '0;
			held_h_q <= '0;
			held_cells_q <= '0;
			rd_status_q <= ogdf_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			bwd_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			i_q <= '0;
			ph_q <= PH_CTR;
			cur_q <= '0;
			dirty_q <= 1'b0;
			changed_q <= 1'b0;
			slot_ok_s1 <= 1'b0;
		end else begin
			if (rsp_accept) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_accept) begin
						if (cmd.op == ogdf_pkg::OP_READ) begin
							if (!field_valid_q) begin
								rd_status_q <= ogdf_pkg::ST_NO_MAP;
							end else if (idx_ext >= held_cells_q) begin
								rd_status_q <= ogdf_pkg::ST_RANGE;
							end else begin
								rd_status_q <= ogdf_pkg::ST_OK;
							end
							state_q <= S_RDOUT;
						end else begin
							field_valid_q <= 1'b0;
							if (occupied) begin
								obstacle_q <= 1'b1;
							end
							if (load_count_q <= CW'(CELL_CAP)) begin
								load_count_q <= load_count_q + CW'(1);
							end
							if (cmd.last_cell) begin
								state_q <= S_CHECK;
							end
						end
					end
				end
				S_RDOUT: begin
					rsp_valid_q <= 1'b1;
					rsp_q.status <= rd_status_q;
					rsp_q.map_valid <= field_valid_q;
					rsp_q.distance <= (rd_status_q == ogdf_pkg::ST_OK) ? mem_rdata_q : '0;
					state_q <= S_IDLE;
				end
				S_CHECK: begin
					load_count_q <= '0;
					obstacle_q <= 1'b0;
					if (!dims_ok || (load_count_q != CW'(dims_prod))) begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= ogdf_pkg::ST_SIZE;
						rsp_q.map_valid <= 1'b0;
						rsp_q.distance <= '0;
						state_q <= S_IDLE;
					end else if (!obstacle_q) begin
						rsp_valid_q <= 1'b1;
						rsp_q.status <= ogdf_pkg::ST_NO_OBST;
						rsp_q.map_valid <= 1'b0;
						rsp_q.distance <= '0;
						state_q <= S_IDLE;
					end else begin
						held_w_q <= width_q;
						held_h_q <= height_q;
						held_cells_q <= CW'(dims_prod);
						bwd_q <= 1'b0;
						x_q <= '0;
						y_q <= '0;
						i_q <= '0;
						ph_q <= PH_CTR;
						changed_q <= 1'b0;
						slot_ok_s1 <= 1'b0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					slot_ok_s1 <= nb_ok;
					if (ph_q == PH_N1) begin
						// center value arrives
						cur_q <= mem_rdata_q;
						dirty_q <= 1'b0;
					end else begin
						cur_q <= cur_d;
						dirty_q <= dirty_d;
					end
					if (ph_q != PH_WR) begin
						ph_q <= ph_q + 3'd1;
					end else begin
						ph_q <= PH_CTR;
						if (!bwd_q) begin
							changed_q <= changed_q || dirty_d;
							if (x_hi) begin
								x_q <= x_q + XB'(1);
								i_q <= i_q + AB'(1);
							end else if (y_hi) begin
								x_q <= '0;
								y_q <= y_q + YB'(1);
								i_q <= i_q + AB'(1);
							end else begin
								// turn around at the last cell
								bwd_q <= 1'b1;
							end
						end else begin
							if (x_lo) begin
								changed_q <= changed_q || dirty_d;
								x_q <= x_q - XB'(1);
								i_q <= i_q - AB'(1);
							end else if (y_lo) begin
								changed_q <= changed_q || dirty_d;
								x_q <= XB'(held_w_q - 9'd1);
								y_q <= y_q - YB'(1);
								i_q <= i_q - AB'(1);
							end else if (changed_q || dirty_d) begin
								// another full iteration is needed
								changed_q <= 1'b0;
								bwd_q <= 1'b0;
								x_q <= '0;
								y_q <= '0;
								i_q <= '0;
							end else begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_FIN: begin
					field_valid_q <= 1'b1;
					rsp_valid_q <= 1'b1;
					rsp_q.status <= ogdf_pkg::ST_OK;
					rsp_q.map_valid <= 1'b1;
					rsp_q.distance <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a read always goes to its response cycle next
	`OGDF_ASSERT_NEXT(a_read_to_rdout, cmd_accept && (cmd.op == ogdf_pkg::OP_READ),
		state_q == S_RDOUT, "read did not reach response cycle")
	// the response register is free whenever a read or finish response is produced
	`OGDF_ASSERT_NOW(a_rsp_free, (state_q == S_RDOUT) || (state_q == S_FIN),
		!rsp_valid_q, "response register busy when a response is produced")
	// the sweep never writes the memory outside its write phase
	`OGDF_ASSERT_NOW(a_sweep_write_phase, (state_q == S_SWEEP) && mem_we,
		ph_q == PH_WR, "sweep wrote the memory outside the write phase")

endmodule
